/* rtl/mppt_pkg.sv */
// ----------------------------------------------------------------------------
// mppt_pkg
// Shared widths, codes, word types and the clamp helper function of the adaptive
// perturb-and-observe tracker.
// ----------------------------------------------------------------------------
package mppt_pkg;

  localparam int VOLT_W     = 17;
  localparam int AMP_W      = 16;
  localparam int WATT_W     = 20;
  localparam int STEP_W     = 16;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int VAL_W      = 25;
  localparam int DIV_NUM_W  = 26;
  localparam int DIV_DEN_W  = 17;

  // |dP*1000/dV|/20 folds into |dP|*50/|dV| with a single truncation.
  localparam logic [6:0]       SLOPE_MUL       = 7'd50;
  localparam logic [AMP_W-1:0] DESCENT_AMP_MIN = 16'd200;
  localparam logic [VAL_W-1:0] PI_KP           = 25'd20;

  localparam logic [VOLT_W-1:0] MIN_REF_RST    = 17'd5000;
  localparam logic [VOLT_W-1:0] ABS_MAX_RST    = 17'd60000;
  localparam logic [VOLT_W-1:0] VOC_MARGIN_RST = 17'd3000;
  localparam logic [STEP_W-1:0] STEP_MIN_RST   = 16'd50;
  localparam logic [STEP_W-1:0] STEP_MAX_RST   = 16'd1000;
  localparam logic [STEP_W-1:0] V_NOISE_RST    = 16'd20;
  localparam logic [WATT_W-1:0] P_NOISE_RST    = 20'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_VOC_PRESET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOC_MARGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_V_NOISE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_P_NOISE    = 3'd7;

  typedef enum logic [1:0] {
    MODE_DISABLED = 2'd0,
    MODE_DESCENT  = 2'd1,
    MODE_TRACKING = 2'd2,
    MODE_LIMITED  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [VOLT_W-1:0] pv_volt;
    logic [AMP_W-1:0]  pv_amp;
    logic [WATT_W-1:0] pv_watt;
    logic              sample_ok;
    logic [WATT_W-1:0] power_allow;
    logic              ext_limited;
    logic [TIME_W-1:0] time_ms;
    logic              restart;
  } in_word_t;

  typedef struct packed {
    logic [WATT_W-1:0] power_request;
    logic [VOLT_W-1:0] ref_volt;
    logic              out_valid;
    logic [1:0]        track_mode;
  } out_word_t;

  // Clamp with the lower bound tested first.
  function automatic logic [WATT_W-1:0] clamp_val(input logic signed [VAL_W-1:0] v,
                                                  input logic [WATT_W-1:0] lo,
                                                  input logic [WATT_W-1:0] hi);
    logic [WATT_W-1:0] res;
    if (v < $signed({5'b0, lo})) begin
      res = lo;
    end else if (v > $signed({5'b0, hi})) begin
      res = hi;
    end else begin
      res = v[WATT_W-1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/mppt_stream_if.sv */
// ----------------------------------------------------------------------------
// mppt_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface mppt_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/mppt_adaptive_po_with_voltage_pi.sv */
// ----------------------------------------------------------------------------
// mppt_adaptive_po_with_voltage_pi
// Adaptive perturb-and-observe maximum power point tracker with a voltage
// PI loop producing a power request, run by a small sequencer around a
// serial divider.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Word                                   | Handshake
//  --------+-----------+----------------------------------------+-----------
//  in_ch   | sink      | sample, allowance, limit, time, restart | valid/ready
//  out_ch  | source    | power request, reference, valid, mode   | valid/ready
//  cfg_*   | sink      | register index and data                 | write enable
//
// An accepted word passes through the states START, ENTRY, SEARCH, PI and
// DONE, where its result is loaded into the output register; leaving disabled
// mode adds ENTRY2, a move adds MOVE, a due PI step adds PI2, and a rejected
// sample goes from START straight to DONE. A tracking step that needs the
// slope division also waits in DIV until the serial divider is done.
// The input is ready only while the sequencer is idle. The output register
// holds a finished word until it is taken, and a new input word may be
// accepted meanwhile. Reset is synchronous; it restores the state and
// configuration registers to their defaults, but not the word registers.
module mppt_adaptive_po_with_voltage_pi #(
  parameter int SEARCH_PERIOD_MS = 100,
  parameter int PI_PERIOD_MS     = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mppt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [mppt_pkg::CFG_DATA_W-1:0] cfg_data,
  mppt_stream_if.sink                     in_ch,
  mppt_stream_if.source                   out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_ENTRY, S_ENTRY2, S_SEARCH, S_DIV, S_MOVE, S_PI, S_PI2, S_DONE
  } state_t;

  localparam int VW = mppt_pkg::VOLT_W;
  localparam int WW = mppt_pkg::WATT_W;
  localparam int SW = mppt_pkg::STEP_W;
  localparam int TW = mppt_pkg::TIME_W;
  localparam int XW = mppt_pkg::VAL_W;

  // Configuration registers.
  logic [VW-1:0] voc_preset_r, min_ref_r, abs_max_r, voc_margin_r;
  logic [SW-1:0] step_min_r, step_max_r, v_noise_r;
  logic [WW-1:0] p_noise_r;

  // Tracker state.
  state_t               state_r, state_nxt;
  mppt_pkg::mode_t      mode_r, mode_nxt;
  logic [VW-1:0]        ref_r, ref_nxt, learned_r, learned_nxt, prev_volt_r, prev_volt_nxt;
  logic [WW-1:0]        prev_watt_r, prev_watt_nxt, integ_r, integ_nxt;
  logic                 prev_ok_r, prev_ok_nxt;
  logic [TW-1:0]        last_search_r, last_search_nxt, last_pi_r, last_pi_nxt;
  logic                 out_v_r, out_v_nxt;

  // Working registers of the word in flight.
  mppt_pkg::in_word_t   x_r;
  mppt_pkg::out_word_t  out_r, out_nxt;
  logic [SW-1:0]        step_r, step_nxt;
  logic                 up_r, up_nxt;
  logic                 ok_r, ok_nxt;
  logic [WW-1:0]        req_r, req_nxt;

  // Divider hookup.
  logic                           div_start, div_done;
  logic [mppt_pkg::DIV_NUM_W-1:0] div_num, div_quot;
  logic [mppt_pkg::DIV_DEN_W-1:0] div_den;

  // Combinational helpers.
  logic [VW-1:0]        ceil_mv, voc_sel;
  logic signed [VW:0]   dv_s;
  logic signed [WW:0]   dp_s;
  logic [VW-1:0]        dv_abs;
  logic [WW-1:0]        dp_abs;
  logic [mppt_pkg::DIV_NUM_W:0] step_sum;
  logic signed [XW-1:0] err, prop, cand, outp, outp2, allow_s, move_val;
  logic                 frozen;

  mppt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // The search ceiling follows the learned open-circuit voltage less the margin
  // when that leaves room below the absolute maximum.
  always_comb begin
    if (learned_r > voc_margin_r && (learned_r - voc_margin_r) < abs_max_r) begin
      ceil_mv = learned_r - voc_margin_r;
    end else begin
      ceil_mv = abs_max_r;
    end
  end

  always_comb begin
    if (learned_r != '0) begin
      voc_sel = learned_r;
    end else if (voc_preset_r != '0) begin
      voc_sel = voc_preset_r;
    end else begin
      voc_sel = x_r.pv_volt;
    end
  end

  // Deltas against the previous sample, as magnitudes for the noise bands.
  assign dv_s   = $signed({1'b0, x_r.pv_volt}) - $signed({1'b0, prev_volt_r});
  assign dp_s   = $signed({1'b0, x_r.pv_watt}) - $signed({1'b0, prev_watt_r});
  assign dv_abs = dv_s[VW] ? VW'(-dv_s) : dv_s[VW-1:0];
  assign dp_abs = dp_s[WW] ? WW'(-dp_s) : dp_s[WW-1:0];

  assign div_num  = mppt_pkg::DIV_NUM_W'(dp_abs * mppt_pkg::SLOPE_MUL);
  assign div_den  = dv_abs;
  assign step_sum = {11'b0, step_min_r} + {1'b0, div_quot};

  // PI terms: error on panel voltage against the reference.
  assign err     = $signed({8'b0, x_r.pv_volt}) - $signed({8'b0, ref_r});
  assign prop    = XW'(err * $signed(mppt_pkg::PI_KP));
  assign cand    = $signed({5'b0, integ_r}) + err;
  assign outp    = prop + cand;
  assign outp2   = prop + $signed({5'b0, integ_r});
  assign allow_s = $signed({5'b0, x_r.power_allow});
  assign frozen  = (outp >= allow_s && err > 0) || (outp <= 0 && err < 0);
  assign move_val = up_r ? ($signed({8'b0, ref_r}) + $signed({9'b0, step_r}))
                         : ($signed({8'b0, ref_r}) - $signed({9'b0, step_r}));

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    ref_nxt         = ref_r;
    learned_nxt     = learned_r;
    prev_volt_nxt   = prev_volt_r;
    prev_watt_nxt   = prev_watt_r;
    prev_ok_nxt     = prev_ok_r;
    integ_nxt       = integ_r;
    last_search_nxt = last_search_r;
    last_pi_nxt     = last_pi_r;
    out_v_nxt       = out_v_r;
    out_nxt         = out_r;
    step_nxt        = step_r;
    up_nxt          = up_r;
    ok_nxt          = ok_r;
    req_nxt         = req_r;
    div_start       = 1'b0;

    if (out_v_r && out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_START;
        end
      end

      // A restart clears everything but the learned open-circuit voltage,
      // and does so even for a rejected sample.
      S_START: begin
        if (x_r.restart) begin
          mode_nxt        = mppt_pkg::MODE_DISABLED;
          ref_nxt         = min_ref_r;
          prev_volt_nxt   = '0;
          prev_watt_nxt   = '0;
          prev_ok_nxt     = 1'b0;
          integ_nxt       = '0;
          last_search_nxt = '0;
          last_pi_nxt     = '0;
        end
        if (!x_r.sample_ok || x_r.power_allow == '0) begin
          ok_nxt    = 1'b0;
          state_nxt = S_DONE;
        end else begin
          ok_nxt    = 1'b1;
          state_nxt = S_ENTRY;
        end
      end

      S_ENTRY: begin
        if (mode_r == mppt_pkg::MODE_DISABLED) begin
          learned_nxt     = voc_sel;
          mode_nxt        = mppt_pkg::MODE_DESCENT;
          prev_ok_nxt     = 1'b0;
          integ_nxt       = '0;
          last_search_nxt = x_r.time_ms;
          last_pi_nxt     = x_r.time_ms;
          state_nxt       = S_ENTRY2;
        end else begin
          state_nxt = S_SEARCH;
        end
      end

      // Start just below the open-circuit voltage, now that it is learned.
      S_ENTRY2: begin
        ref_nxt   = VW'(mppt_pkg::clamp_val(
                      $signed({8'b0, learned_r}) - $signed({8'b0, voc_margin_r}),
                      {3'b0, min_ref_r}, {3'b0, ceil_mv}));
        state_nxt = S_SEARCH;
      end

      S_SEARCH: begin
        state_nxt = S_PI;
        if ((x_r.time_ms - last_search_r) >= TW'(SEARCH_PERIOD_MS)) begin
          last_search_nxt = x_r.time_ms;
          prev_volt_nxt   = x_r.pv_volt;
          prev_watt_nxt   = x_r.pv_watt;
          if (x_r.ext_limited) begin
            mode_nxt    = mppt_pkg::MODE_LIMITED;
            prev_ok_nxt = 1'b1;
          end else if (mode_r == mppt_pkg::MODE_DESCENT) begin
            prev_ok_nxt = 1'b1;
            if (x_r.pv_amp > mppt_pkg::DESCENT_AMP_MIN && x_r.pv_watt > p_noise_r) begin
              mode_nxt = mppt_pkg::MODE_TRACKING;
            end
            ref_nxt = VW'(mppt_pkg::clamp_val(
                        $signed({8'b0, ref_r}) - $signed({9'b0, step_max_r}),
                        {3'b0, min_ref_r}, {3'b0, ceil_mv}));
          end else if (!prev_ok_r) begin
            prev_ok_nxt = 1'b1;
          end else if (dv_abs >= {1'b0, v_noise_r} && dp_abs >= p_noise_r) begin
            up_nxt = (dp_s > 0 && dv_s > 0) || (dp_s < 0 && dv_s < 0);
            if (dv_s == 0) begin
              step_nxt  = step_min_r;
              state_nxt = S_MOVE;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          step_nxt  = (step_sum > {11'b0, step_max_r}) ? step_max_r : step_sum[SW-1:0];
          state_nxt = S_MOVE;
        end
      end

      S_MOVE: begin
        mode_nxt  = mppt_pkg::MODE_TRACKING;
        ref_nxt   = VW'(mppt_pkg::clamp_val(move_val, {3'b0, min_ref_r}, {3'b0, ceil_mv}));
        state_nxt = S_PI;
      end

      // Conditional integration: the integrator holds while the output is
      // pinned against a limit and the error pushes further into it.
      S_PI: begin
        if ((x_r.time_ms - last_pi_r) >= TW'(PI_PERIOD_MS)) begin
          last_pi_nxt = x_r.time_ms;
          integ_nxt   = mppt_pkg::clamp_val(frozen ? $signed({5'b0, integ_r}) : cand,
                                            '0, x_r.power_allow);
          state_nxt   = S_PI2;
        end else begin
          req_nxt   = (integ_r > x_r.power_allow) ? x_r.power_allow : integ_r;
          state_nxt = S_DONE;
        end
      end

      S_PI2: begin
        req_nxt   = mppt_pkg::clamp_val(outp2, '0, x_r.power_allow);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_v_r || out_ch.ready) begin
          out_v_nxt             = 1'b1;
          out_nxt.power_request = ok_r ? req_r : '0;
          out_nxt.ref_volt      = ok_r ? ref_r : '0;
          out_nxt.out_valid     = ok_r;
          out_nxt.track_mode    = ok_r ? mode_r : mppt_pkg::MODE_DISABLED;
          state_nxt             = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      mode_r        <= mppt_pkg::MODE_DISABLED;
      ref_r         <= mppt_pkg::MIN_REF_RST;
      learned_r     <= '0;
      prev_volt_r   <= '0;
      prev_watt_r   <= '0;
      prev_ok_r     <= 1'b0;
      integ_r       <= '0;
      last_search_r <= '0;
      last_pi_r     <= '0;
      out_v_r       <= 1'b0;
      voc_preset_r  <= '0;
      min_ref_r     <= mppt_pkg::MIN_REF_RST;
      abs_max_r     <= mppt_pkg::ABS_MAX_RST;
      voc_margin_r  <= mppt_pkg::VOC_MARGIN_RST;
      step_min_r    <= mppt_pkg::STEP_MIN_RST;
      step_max_r    <= mppt_pkg::STEP_MAX_RST;
      v_noise_r     <= mppt_pkg::V_NOISE_RST;
      p_noise_r     <= mppt_pkg::P_NOISE_RST;
    end else begin
      state_r       <= state_nxt;
      mode_r        <= mode_nxt;
      ref_r         <= ref_nxt;
      learned_r     <= learned_nxt;
      prev_volt_r   <= prev_volt_nxt;
      prev_watt_r   <= prev_watt_nxt;
      prev_ok_r     <= prev_ok_nxt;
      integ_r       <= integ_nxt;
      last_search_r <= last_search_nxt;
      last_pi_r     <= last_pi_nxt;
      out_v_r       <= out_v_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          mppt_pkg::CFG_VOC_PRESET: voc_preset_r <= cfg_data[VW-1:0];
          mppt_pkg::CFG_MIN_REF:    min_ref_r    <= cfg_data[VW-1:0];
          mppt_pkg::CFG_ABS_MAX:    abs_max_r    <= cfg_data[VW-1:0];
          mppt_pkg::CFG_VOC_MARGIN: voc_margin_r <= cfg_data[VW-1:0];
          mppt_pkg::CFG_STEP_MIN:   step_min_r   <= cfg_data[SW-1:0];
          mppt_pkg::CFG_STEP_MAX:   step_max_r   <= cfg_data[SW-1:0];
          mppt_pkg::CFG_V_NOISE:    v_noise_r    <= cfg_data[SW-1:0];
          mppt_pkg::CFG_P_NOISE:    p_noise_r    <= cfg_data[WW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Word registers carry no reset.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      x_r <= in_ch.data;
    end
    out_r  <= out_nxt;
    step_r <= step_nxt;
    up_r   <= up_nxt;
    ok_r   <= ok_nxt;
    req_r  <= req_nxt;
  end

endmodule

/* rtl/mppt_div.sv */
// ----------------------------------------------------------------------------
// mppt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mppt_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mppt_pkg::DIV_NUM_W-1:0] num,
  input  logic [mppt_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [mppt_pkg::DIV_NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(mppt_pkg::DIV_NUM_W);

  logic                           busy_r, done_r;
  logic [CNT_W-1:0]               cnt_r;
  logic [mppt_pkg::DIV_DEN_W:0]   rem_r;
  logic [mppt_pkg::DIV_NUM_W-1:0] quot_r;
  logic [mppt_pkg::DIV_DEN_W-1:0] den_r;
  logic [mppt_pkg::DIV_DEN_W:0]   shifted;
  logic                           fits;

  assign shifted = {rem_r[mppt_pkg::DIV_DEN_W-1:0], quot_r[mppt_pkg::DIV_NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(mppt_pkg::DIV_NUM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quot_r <= num;
      den_r  <= den;
    end else if (busy_r) begin
      rem_r  <= fits ? (shifted - {1'b0, den_r}) : shifted;
      quot_r <= {quot_r[mppt_pkg::DIV_NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

/* dv/mppt_adaptive_po_with_voltage_pi_tb.sv */
// ----------------------------------------------------------------------------
// mppt_adaptive_po_with_voltage_pi_tb
// Self-checking bench for the adaptive perturb-and-observe tracker: words are
// driven through a bursty valid/ready source, results are taken by a stalling
// sink and compared field by field with a behavioural predictor of the block.
// ----------------------------------------------------------------------------
module mppt_adaptive_po_with_voltage_pi_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEARCH_MS = 100;
  localparam int PI_MS     = 10;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [mppt_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [mppt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  mppt_stream_if #(.word_t(mppt_pkg::in_word_t))  in_ch();
  mppt_stream_if #(.word_t(mppt_pkg::out_word_t)) out_ch();

  mppt_adaptive_po_with_voltage_pi #(
    .SEARCH_PERIOD_MS(SEARCH_MS),
    .PI_PERIOD_MS(PI_MS)
  ) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // A 12 ns clock, high and low for half a period each.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Register copies held by the predictor, kept at the block's widths.
  logic [mppt_pkg::VOLT_W-1:0] voc_preset, min_ref, abs_max, voc_margin;
  logic [mppt_pkg::STEP_W-1:0] step_min, step_max, v_noise;
  logic [mppt_pkg::WATT_W-1:0] p_noise;

  // Tracker state as the predictor sees it.
  mppt_pkg::mode_t             trk_mode;
  logic [mppt_pkg::VOLT_W-1:0] ref_mv, learned_voc, prev_volt;
  logic [mppt_pkg::WATT_W-1:0] prev_watt;
  logic                        prev_ok;
  longint                      integ;
  logic [mppt_pkg::TIME_W-1:0] last_search, last_pi;

  mppt_pkg::in_word_t  pending_words[$];
  mppt_pkg::out_word_t expected_results[$];
  int        errors = 0;
  int        words_sent = 0;
  int        results_seen = 0;
  int        restarts_sent = 0;
  int        rejects_sent = 0;
  longint    cycles = 0;
  logic [mppt_pkg::TIME_W-1:0] now_ms;
  bit        in_taken = 1'b0;

  function automatic longint clamp_lohi(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint ceiling_ref();
    if (learned_voc > voc_margin && longint'(learned_voc) - voc_margin < abs_max)
      return longint'(learned_voc) - voc_margin;
    return abs_max;
  endfunction

  function automatic longint adaptive_step(longint dp, longint dv);
    longint s, st;
    if (dv == 0) return step_min;
    s = (dp * 1000) / dv;
    if (s < 0) s = -s;
    st = longint'(step_min) + s / 20;
    if (st > step_max) st = step_max;
    return st;
  endfunction

  function automatic void clear_tracker();
    trk_mode = mppt_pkg::MODE_DISABLED;
    ref_mv = min_ref;
    prev_volt = '0;
    prev_watt = '0;
    prev_ok = 1'b0;
    integ = 0;
    last_search = '0;
    last_pi = '0;
  endfunction

  // One search step: the limit flag, descent, then slope-adaptive perturb-and-observe.
  function automatic void search_step(mppt_pkg::in_word_t w);
    longint dv, dp, nxt;
    if (w.ext_limited) begin
      trk_mode = mppt_pkg::MODE_LIMITED;
      prev_volt = w.pv_volt; prev_watt = w.pv_watt; prev_ok = 1'b1;
      return;
    end
    if (trk_mode == mppt_pkg::MODE_DESCENT) begin
      prev_volt = w.pv_volt; prev_watt = w.pv_watt; prev_ok = 1'b1;
      nxt = longint'(ref_mv) - step_max;
      if (w.pv_amp > 200 && w.pv_watt > p_noise) trk_mode = mppt_pkg::MODE_TRACKING;
      ref_mv = mppt_pkg::VOLT_W'(clamp_lohi(nxt, min_ref, ceiling_ref()));
      return;
    end
    if (!prev_ok) begin
      prev_volt = w.pv_volt; prev_watt = w.pv_watt; prev_ok = 1'b1;
      return;
    end
    dv = longint'(w.pv_volt) - prev_volt;
    dp = longint'(w.pv_watt) - prev_watt;
    prev_volt = w.pv_volt;
    prev_watt = w.pv_watt;
    if (dv > -longint'(v_noise) && dv < longint'(v_noise)) return;
    if (dp > -longint'(p_noise) && dp < longint'(p_noise)) return;
    if ((dp > 0 && dv > 0) || (dp < 0 && dv < 0))
      nxt = longint'(ref_mv) + adaptive_step(dp, dv);
    else
      nxt = longint'(ref_mv) - adaptive_step(dp, dv);
    trk_mode = mppt_pkg::MODE_TRACKING;
    ref_mv = mppt_pkg::VOLT_W'(clamp_lohi(nxt, min_ref, ceiling_ref()));
  endfunction

  // Works out the result word that one accepted input word gives.
  function automatic mppt_pkg::out_word_t predict_tracker(mppt_pkg::in_word_t w);
    mppt_pkg::out_word_t r;
    logic [mppt_pkg::VOLT_W-1:0] voc;
    longint err, prop, cand, outp, req;
    r = '0;
    if (w.restart) clear_tracker();
    if (!w.sample_ok || w.power_allow == 0) return r;
    if (trk_mode == mppt_pkg::MODE_DISABLED) begin
      voc = learned_voc != 0 ? learned_voc : (voc_preset != 0 ? voc_preset : w.pv_volt);
      learned_voc = voc;
      ref_mv = mppt_pkg::VOLT_W'(clamp_lohi(longint'(voc) - voc_margin, min_ref,
                                            ceiling_ref()));
      trk_mode = mppt_pkg::MODE_DESCENT;
      prev_ok = 1'b0;
      integ = 0;
      last_search = w.time_ms;
      last_pi = w.time_ms;
    end
    if (mppt_pkg::TIME_W'(w.time_ms - last_search) >= SEARCH_MS) begin
      search_step(w);
      last_search = w.time_ms;
    end
    if (mppt_pkg::TIME_W'(w.time_ms - last_pi) >= PI_MS) begin
      err = longint'(w.pv_volt) - ref_mv;
      prop = err * 20;
      cand = integ + err;
      outp = prop + cand;
      if (!((outp >= w.power_allow && err > 0) || (outp <= 0 && err < 0))) integ = cand;
      if (integ < 0) integ = 0;
      if (integ > w.power_allow) integ = w.power_allow;
      req = clamp_lohi(prop + integ, 0, w.power_allow);
      last_pi = w.time_ms;
    end else begin
      req = clamp_lohi(integ, 0, w.power_allow);
    end
    r.power_request = mppt_pkg::WATT_W'(req);
    r.ref_volt = ref_mv;
    r.out_valid = 1'b1;
    r.track_mode = trk_mode;
    return r;
  endfunction

  // Driver: bursts of random length separated by random gaps. A word is
  // predicted and retired from the queue at the edge at which it is accepted,
  // so the store of expected results always matches the block's order.
  int burst_left = 0;
  int gap_left = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
  end

  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      expected_results.push_back(predict_tracker(in_ch.data));
      void'(pending_words.pop_front());
      words_sent++;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || in_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= pending_words[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls in its own pattern: long runs of readiness broken by
  // stalls of random length.
  int stall_left = 0;
  initial out_ch.ready = 1'b0;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 60);
    end
  end

  // Monitor: each accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    mppt_pkg::out_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $realtime, out_ch.data);
        errors++;
      end else begin
        exp_w = expected_results.pop_front();
        if (out_ch.data.power_request !== exp_w.power_request) begin
          $display("%0t: power_request expected %0d actual %0d", $realtime,
                   exp_w.power_request, out_ch.data.power_request);
          errors++;
        end
        if (out_ch.data.ref_volt !== exp_w.ref_volt) begin
          $display("%0t: ref_volt expected %0d actual %0d", $realtime,
                   exp_w.ref_volt, out_ch.data.ref_volt);
          errors++;
        end
        if (out_ch.data.out_valid !== exp_w.out_valid) begin
          $display("%0t: out_valid expected %0b actual %0b", $realtime,
                   exp_w.out_valid, out_ch.data.out_valid);
          errors++;
        end
        if (out_ch.data.track_mode !== exp_w.track_mode) begin
          $display("%0t: track_mode expected %0d actual %0d", $realtime,
                   exp_w.track_mode, out_ch.data.track_mode);
          errors++;
        end
      end
    end
  end

  // Cycle counter with a generous limit: the slowest correct run is up to about
  // 2550 words each waiting out gaps, the divider and receiver stalls.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Writes one register on the falling edge and keeps the predictor's copy.
  task automatic write_reg(input logic [mppt_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[mppt_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mppt_pkg::CFG_VOC_PRESET: voc_preset = val[mppt_pkg::VOLT_W-1:0];
      mppt_pkg::CFG_MIN_REF:    min_ref    = val[mppt_pkg::VOLT_W-1:0];
      mppt_pkg::CFG_ABS_MAX:    abs_max    = val[mppt_pkg::VOLT_W-1:0];
      mppt_pkg::CFG_VOC_MARGIN: voc_margin = val[mppt_pkg::VOLT_W-1:0];
      mppt_pkg::CFG_STEP_MIN:   step_min   = val[mppt_pkg::STEP_W-1:0];
      mppt_pkg::CFG_STEP_MAX:   step_max   = val[mppt_pkg::STEP_W-1:0];
      mppt_pkg::CFG_V_NOISE:    v_noise    = val[mppt_pkg::STEP_W-1:0];
      default:                  p_noise    = val[mppt_pkg::WATT_W-1:0];
    endcase
  endtask

  // Waits until every queued word has been taken and every result checked;
  // the block is then idle.
  task automatic drain();
    while (pending_words.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Builds one word; the time advances by the given step.
  function automatic mppt_pkg::in_word_t make_word(int unsigned v, int unsigned a,
                                                   int unsigned p, bit ok,
                                                   int unsigned allow, bit lim,
                                                   int unsigned dt, bit rs);
    mppt_pkg::in_word_t w;
    now_ms += dt;
    w.pv_volt = v[mppt_pkg::VOLT_W-1:0];
    w.pv_amp = a[mppt_pkg::AMP_W-1:0];
    w.pv_watt = p[mppt_pkg::WATT_W-1:0];
    w.sample_ok = ok;
    w.power_allow = allow[mppt_pkg::WATT_W-1:0];
    w.ext_limited = lim;
    w.time_ms = now_ms;
    w.restart = rs;
    if (rs) restarts_sent++;
    if (!ok || allow == 0) rejects_sent++;
    return w;
  endfunction

  // A restart followed by a session around a moving panel peak, with occasional rejected samples, limits and restarts.
  task automatic queue_session(int unsigned n_words);
    int unsigned peak, v, dv_mag, allow;
    int unsigned p;
    longint d;
    peak = $urandom_range(1000, 120000);
    v = peak + $urandom_range(0, 8000);
    allow = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 1048575) : $urandom_range(1, 500000);
    pending_words.push_back(make_word(v, $urandom_range(0, 65535), $urandom_range(0, 1048575),
                                      1, allow, 0, $urandom_range(0, 200), 1));
    for (int i = 0; i < n_words; i++) begin
      if ($urandom_range(0, 4) == 0) peak = $urandom_range(1000, 120000);
      dv_mag = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 3000);
      v = ($urandom_range(0, 1)) ? v + dv_mag : ((v > dv_mag) ? v - dv_mag : 0);
      if (v > 131071) v = 131071;
      d = longint'(v) - peak;
      if (d < 0) d = -d;
      p = (d > 100000) ? 0 : 32'((100000 - d) * 8);
      if ($urandom_range(0, 3) == 0) p = p ^ $urandom_range(0, 1023);
      if (p > 1048575) p = 1048575;
      pending_words.push_back(make_word(
        v, $urandom_range(0, 3000), p,
        $urandom_range(0, 19) != 0,
        ($urandom_range(0, 29) == 0) ? 0 : allow,
        $urandom_range(0, 14) == 0,
        ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 130),
        $urandom_range(0, 60) == 0));
    end
  endtask

  initial begin
    voc_preset = '0;
    min_ref = mppt_pkg::MIN_REF_RST;
    abs_max = mppt_pkg::ABS_MAX_RST;
    voc_margin = mppt_pkg::VOC_MARGIN_RST;
    step_min = mppt_pkg::STEP_MIN_RST;
    step_max = mppt_pkg::STEP_MAX_RST;
    v_noise = mppt_pkg::V_NOISE_RST;
    p_noise = mppt_pkg::P_NOISE_RST;
    learned_voc = '0;
    clear_tracker();
    now_ms = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset settings: rejected samples, the learning of
    // the open-circuit voltage, descent, zero allowance, full-scale fields,
    // the limit flag, a time wrap and a restart.
    pending_words.push_back(make_word(40000, 1000, 50000, 0, 1000, 0, 0, 0));
    pending_words.push_back(make_word(40000, 1000, 50000, 1, 0, 0, 0, 0));
    pending_words.push_back(make_word(40000, 300, 50000, 1, 100000, 0, 5, 0));
    pending_words.push_back(make_word(39000, 300, 50000, 1, 100000, 0, 10, 0));
    pending_words.push_back(make_word(38000, 100, 50, 1, 100000, 0, 100, 0));
    pending_words.push_back(make_word(37000, 300, 60000, 1, 100000, 0, 100, 0));
    pending_words.push_back(make_word(36000, 300, 50000, 1, 100000, 0, 100, 0));
    pending_words.push_back(make_word(35000, 300, 55000, 1, 100000, 0, 100, 0));
    pending_words.push_back(make_word(35010, 300, 55000, 1, 100000, 0, 100, 0));
    pending_words.push_back(make_word(36000, 300, 55050, 1, 100000, 0, 100, 0));
    pending_words.push_back(make_word(131071, 65535, 1048575, 1, 1048575, 0, 100, 0));
    pending_words.push_back(make_word(0, 0, 0, 1, 1048575, 0, 100, 0));
    pending_words.push_back(make_word(30000, 300, 40000, 1, 1, 1, 100, 0));
    pending_words.push_back(make_word(31000, 300, 90000, 1, 1, 1, 3, 0));
    pending_words.push_back(make_word(32000, 300, 30000, 1, 5000, 0, 100, 0));
    pending_words.push_back(make_word(33000, 300, 30000, 1, 5000, 0, 32'hFFFF_FFF0, 0));
    pending_words.push_back(make_word(34000, 300, 31000, 1, 5000, 0, 150, 0));
    pending_words.push_back(make_word(20000, 300, 31000, 0, 5000, 0, 0, 1));
    pending_words.push_back(make_word(20000, 300, 31000, 1, 5000, 0, 10, 0));
    drain();

    // Crossed limits, zero noise bands and a preset open-circuit voltage.
    write_reg(mppt_pkg::CFG_VOC_PRESET, 50000);
    write_reg(mppt_pkg::CFG_MIN_REF, 70000);
    write_reg(mppt_pkg::CFG_ABS_MAX, 0);
    write_reg(mppt_pkg::CFG_VOC_MARGIN, 0);
    write_reg(mppt_pkg::CFG_STEP_MIN, 65535);
    write_reg(mppt_pkg::CFG_STEP_MAX, 0);
    write_reg(mppt_pkg::CFG_V_NOISE, 0);
    write_reg(mppt_pkg::CFG_P_NOISE, 0);
    pending_words.push_back(make_word(1000, 65535, 0, 1, 1000, 0, 0, 1));
    pending_words.push_back(make_word(1000, 300, 500, 1, 1000, 0, 100, 0));
    pending_words.push_back(make_word(1000, 300, 700, 1, 1000, 0, 100, 0));
    pending_words.push_back(make_word(900, 300, 600, 1, 1000, 0, 100, 0));
    drain();

    // Random phases, each under a setting of its own, the extremes included.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(mppt_pkg::CFG_VOC_PRESET, 0);
          write_reg(mppt_pkg::CFG_MIN_REF, mppt_pkg::MIN_REF_RST);
          write_reg(mppt_pkg::CFG_ABS_MAX, mppt_pkg::ABS_MAX_RST);
          write_reg(mppt_pkg::CFG_VOC_MARGIN, mppt_pkg::VOC_MARGIN_RST);
          write_reg(mppt_pkg::CFG_STEP_MIN, mppt_pkg::STEP_MIN_RST);
          write_reg(mppt_pkg::CFG_STEP_MAX, mppt_pkg::STEP_MAX_RST);
          write_reg(mppt_pkg::CFG_V_NOISE, mppt_pkg::V_NOISE_RST);
          write_reg(mppt_pkg::CFG_P_NOISE, mppt_pkg::P_NOISE_RST);
        end
        1: begin
          write_reg(mppt_pkg::CFG_VOC_PRESET, 131071);
          write_reg(mppt_pkg::CFG_ABS_MAX, 131071);
          write_reg(mppt_pkg::CFG_MIN_REF, 0);
          write_reg(mppt_pkg::CFG_VOC_MARGIN, 131071);
          write_reg(mppt_pkg::CFG_STEP_MAX, 65535);
          write_reg(mppt_pkg::CFG_P_NOISE, 1048575);
        end
        default: begin
          write_reg(mppt_pkg::CFG_VOC_PRESET,
                    ($urandom_range(0, 1)) ? 0 : $urandom_range(0, 131071));
          write_reg(mppt_pkg::CFG_MIN_REF, $urandom_range(0, 20000));
          write_reg(mppt_pkg::CFG_ABS_MAX, $urandom_range(20000, 131071));
          write_reg(mppt_pkg::CFG_VOC_MARGIN, $urandom_range(0, 10000));
          write_reg(mppt_pkg::CFG_STEP_MIN, $urandom_range(0, 300));
          write_reg(mppt_pkg::CFG_STEP_MAX, $urandom_range(100, 5000));
          write_reg(mppt_pkg::CFG_V_NOISE, $urandom_range(0, 60));
          write_reg(mppt_pkg::CFG_P_NOISE, $urandom_range(0, 600));
        end
      endcase
      for (int s = 0; s < 6; s++) queue_session($urandom_range(20, 50));
      // A little noise: fully random words.
      for (int k = 0; k < 10; k++)
        pending_words.push_back(make_word($urandom_range(0, 131071), $urandom_range(0, 65535),
          $urandom_range(0, 1048575), $urandom_range(0, 1), $urandom_range(0, 1048575),
          $urandom_range(0, 1), $urandom(), $urandom_range(0, 1)));
      drain();
    end

    repeat (100) @(posedge clk);
    $display("Run covered %0d words and %0d results, %0d restarts, %0d rejected samples,",
             words_sent, results_seen, restarts_sent, rejects_sent);
    $display("over directed corners and ten register settings including the extremes.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
